@@ rtl/dstt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline sorted task table package
// Field widths, operation and status codes, controller states and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package dstt_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned MAX_RESULTS  = 16;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned KEY_W    = 16;
   localparam int unsigned TAG_W    = 16;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned RANK_W   = 5;
   localparam int unsigned COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_LIST   = 2'd1,
      KIND_REMOVE = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK      = 3'd0,
      RSP_FULL    = 3'd1,
      RSP_EMPTY   = 3'd2,
      RSP_INVALID = 3'd3,
      RSP_CANCEL  = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SORT,
      ST_FINISH,
      ST_LIST,
      ST_RESP
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           capture;
      logic           append;
      logic           sort_start;
      logic           sort_step;
      logic           remove;
      logic           load_status;
      logic           load_entry;
      rsp_status_type code;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_add;
      logic is_list;
      logic is_remove;
      logic full;
      logic empty;
      logic pos_zero;
      logic pos_bad;
      logic sort_last;
      logic list_last;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/dstt_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per request.
// ----------------------------------------------------------------------------
interface dstt_req_if
   import dstt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [KEY_W-1:0]  deadline;
   logic [TAG_W-1:0]  tag;
   logic [POS_W-1:0]  position;

   modport source (output valid, kind, deadline, tag, position, input ready);
   modport sink   (input valid, kind, deadline, tag, position, output ready);
endinterface
`default_nettype wire

@@ rtl/dstt_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface dstt_rsp_if
   import dstt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RANK_W-1:0]   rank;
   logic [KEY_W-1:0]    entry_deadline;
   logic [TAG_W-1:0]    entry_tag;
   logic [COUNT_W-1:0]  entry_count;
   logic                last;

   modport source (output valid, status, rank, entry_deadline, entry_tag,
                   entry_count, last, input ready);
   modport sink   (input valid, status, rank, entry_deadline, entry_tag,
                   entry_count, last, output ready);
endinterface
`default_nettype wire

@@ rtl/dstt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline sorted task table datapath
// Entry row with odd-even transposition sorting, shift-down removal,
// readout pointer and the response register.
// ----------------------------------------------------------------------------
module dstt_datapath
   import dstt_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [KEY_W-1:0]    req_deadline,
   input  logic [TAG_W-1:0]    req_tag,
   input  logic [POS_W-1:0]    req_position,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [KEY_W-1:0]    rsp_entry_deadline,
   output logic [TAG_W-1:0]    rsp_entry_tag,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   output logic                rsp_last,
   input  dp_cmd_type          cmd,
   output dp_status_type       stat
);

   localparam int unsigned CW  = $clog2(CAPACITY + 1);
   localparam int unsigned IW  = $clog2(CAPACITY);
   localparam int unsigned LW  = (CW > POS_W) ? CW : POS_W;

   logic [KEY_W-1:0]   key_ff [CAPACITY];
   logic [KEY_W-1:0]   key_in [CAPACITY];
   logic [TAG_W-1:0]   tag_ff [CAPACITY];
   logic [TAG_W-1:0]   tag_in [CAPACITY];
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      phase_ff, phase_in;
   logic [IW-1:0]      rd_ff, rd_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [KEY_W-1:0]   new_key_ff;
   logic [TAG_W-1:0]   new_tag_ff;
   logic [POS_W-1:0]   pos_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [RANK_W-1:0]   rsp_rank_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   logic [LW-1:0] count_wide;
   logic [LW-1:0] list_len;
   logic [LW-1:0] rd_next_wide;
   logic [LW-1:0] pos_wide;

   assign count_wide   = LW'(count_ff);
   assign list_len     = (count_wide > LW'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : count_wide;
   assign rd_next_wide = LW'(rd_ff) + LW'(1);
   assign pos_wide     = LW'(pos_ff);

   always_comb begin
      stat.is_add    = (kind_ff == KIND_ADD);
      stat.is_list   = (kind_ff == KIND_LIST);
      stat.is_remove = (kind_ff == KIND_REMOVE);
      stat.full      = (count_ff >= CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.pos_zero  = (pos_ff == '0);
      stat.pos_bad   = (pos_wide > count_wide);
      stat.sort_last = (phase_ff == IW'(CAPACITY - 1));
      stat.list_last = (rd_next_wide == list_len);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Entry row update: append at the fill point, one transposition phase
   // over disjoint neighbor pairs, or a shift down over the removed slot.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i] = key_ff[i];
         tag_in[i] = tag_ff[i];
      end
      count_in = count_ff;
      if (cmd.append) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == count_ff) begin
               key_in[i] = new_key_ff;
               tag_in[i] = new_tag_ff;
            end
         end
         count_in = count_ff + CW'(1);
      end
      if (cmd.sort_step) begin
         for (int j = 0; j < CAPACITY - 1; j++) begin
            if ((j % 2) == int'(phase_ff[0]) && CW'(j + 1) < count_ff &&
                key_ff[j] > key_ff[j+1]) begin
               key_in[j]   = key_ff[j+1];
               key_in[j+1] = key_ff[j];
               tag_in[j]   = tag_ff[j+1];
               tag_in[j+1] = tag_ff[j];
            end
         end
      end
      if (cmd.remove) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (LW'(i) >= pos_wide - LW'(1)) begin
               key_in[i] = key_ff[i+1];
               tag_in[i] = tag_ff[i+1];
            end
         end
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      rd_in    = rd_ff;
      if (cmd.sort_start) begin
         phase_in = '0;
         rd_in    = '0;
      end else begin
         if (cmd.sort_step) begin
            phase_in = phase_ff + IW'(1);
         end
         if (cmd.load_entry) begin
            rd_in = rd_ff + IW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_status || cmd.load_entry) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_W'(KIND_ADD);
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.capture) begin
            kind_ff <= req_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i] <= key_in[i];
         tag_ff[i] <= tag_in[i];
      end
      phase_ff <= phase_in;
      rd_ff    <= rd_in;
      if (cmd.capture) begin
         new_key_ff <= req_deadline;
         new_tag_ff <= req_tag;
         pos_ff     <= req_position;
      end
      if (cmd.load_entry) begin
         rsp_status_ff <= RSP_OK;
         rsp_rank_ff   <= RANK_W'(rd_next_wide);
         rsp_key_ff    <= key_ff[rd_ff];
         rsp_tag_ff    <= tag_ff[rd_ff];
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_last_ff   <= stat.list_last;
      end else if (cmd.load_status) begin
         rsp_status_ff <= cmd.code;
         rsp_rank_ff   <= '0;
         rsp_key_ff    <= '0;
         rsp_tag_ff    <= '0;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_rank           = rsp_rank_ff;
   assign rsp_entry_deadline = rsp_key_ff;
   assign rsp_entry_tag      = rsp_tag_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_last           = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count exceeds capacity");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_entry) |-> stat.rsp_free)
      else $error("response register overwritten while held");

   a_append_room : assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !stat.full)
      else $error("append on a full table");

   a_remove_count : assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - CW'(1))
      else $error("removal did not shrink the table by one");

endmodule
`default_nettype wire

@@ rtl/dstt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline sorted task table controller
// Sequences capture, sorting, removal, listing and responses.
// ----------------------------------------------------------------------------
module dstt_controller
   import dstt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctl_state_type  state_ff, state_in;
   rsp_status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_add) begin
               code_in  = stat.full ? RSP_FULL : RSP_OK;
               state_in = ST_RESP;
            end else if (stat.is_list || stat.is_remove) begin
               if (stat.empty) begin
                  code_in  = RSP_EMPTY;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SORT;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SORT: begin
            if (stat.sort_last) begin
               state_in = stat.is_list ? ST_LIST : ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.pos_zero) begin
               code_in = RSP_CANCEL;
            end else if (stat.pos_bad) begin
               code_in = RSP_INVALID;
            end else begin
               code_in = RSP_OK;
            end
            state_in = ST_RESP;
         end
         ST_LIST: begin
            if (stat.rsp_free && stat.list_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd.capture     = 1'b0;
      cmd.append      = 1'b0;
      cmd.sort_start  = 1'b0;
      cmd.sort_step   = 1'b0;
      cmd.remove      = 1'b0;
      cmd.load_status = 1'b0;
      cmd.load_entry  = 1'b0;
      cmd.code        = code_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.append     = stat.is_add && !stat.full;
            cmd.sort_start = (stat.is_list || stat.is_remove) && !stat.empty;
         end
         ST_SORT: begin
            cmd.sort_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.remove = !stat.pos_zero && !stat.pos_bad;
         end
         ST_LIST: begin
            cmd.load_entry = stat.rsp_free;
         end
         ST_RESP: begin
            cmd.load_status = stat.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= RSP_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.sort_step, cmd.remove, cmd.load_status,
                cmd.load_entry}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire

@@ rtl/deadline_sorted_task_table.sv @@
// Sequence: an add is captured, decoded and then answered through the
// response register; a list or remove is first captured, decoded and sorted,
// after which a list emits one entry a cycle while the response channel
// takes them, and a remove checks its position and gives its single result.
// Throughput: one request at a time; the next is taken once the last result
// of the current one is loaded into the response register.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline sorted task table
// Table of deadline/tag entries with append, stable sorted listing and
// removal by sorted position.
// ----------------------------------------------------------------------------
//
// Reset (synchronous, active high) empties the table and drops any response.
//
// The block is split into a controller and a datapath. The controller takes
// one request at a time: it captures the request, decodes it, and then steps
// through sorting, removal or readout before returning to idle.
//
// Sorting uses odd-even transposition over the entry row: in each cycle
// every other neighbor pair below the fill count is compared, and a pair is
// swapped only when the left key is strictly larger. Since equal keys never
// swap, the order reached is the stable ascending order, identical to what a
// bubble sort gives. CAPACITY phases always suffice, and all of them run
// regardless of fill.
//
// Removal shifts every entry above the removed slot down by one. Listing
// reads one entry per cycle through a pointer while the response register
// is free, and emits at most sixteen results, with the final one marked last.
//
// Results wait in a response register; the controller only loads it when it
// is empty or being drained in the same cycle, so nothing is lost under
// backpressure.
module deadline_sorted_task_table
   import dstt_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dstt_req_if.sink   req_chan,
   dstt_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   // Sequencing of each request.
   dstt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry storage, sorting network step and response register.
   dstt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_chan.kind),
      .req_deadline       (req_chan.deadline),
      .req_tag            (req_chan.tag),
      .req_position       (req_chan.position),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_rank           (rsp_chan.rank),
      .rsp_entry_deadline (rsp_chan.entry_deadline),
      .rsp_entry_tag      (rsp_chan.entry_tag),
      .rsp_entry_count    (rsp_chan.entry_count),
      .rsp_last           (rsp_chan.last),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline sorted task table testbench
// Drives add, list and remove requests through the request channel, keeps a
// shadow copy of the table to predict every result, and checks each result
// field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import dstt_pkg::*;

   localparam int unsigned CAPACITY       = 16;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 4 * CAPACITY;
   localparam int unsigned RANDOM_OPS     = 385;
   localparam int unsigned MAX_REPORTS    = 10;

   // The kind field has one code that the block ignores. It must still be
   // sent, so it gets a name of its own here.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One request as queued for the driver. A set hold_until_drained flag
   // makes the driver wait until every predicted result has come back
   // before it presents this request.
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  deadline;
      logic [TAG_W-1:0]  tag;
      logic [POS_W-1:0]  position;
      bit                hold_until_drained;
   } table_op_type;

   // One predicted result.
   typedef struct {
      rsp_status_type     status;
      logic [RANK_W-1:0]  rank;
      logic [KEY_W-1:0]   entry_deadline;
      logic [TAG_W-1:0]   entry_tag;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } table_rsp_type;

   logic clock;
   logic reset;

   dstt_req_if req_chan ();
   dstt_rsp_if rsp_chan ();

   deadline_sorted_task_table #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Requests still to be sent, and results predicted but not yet seen.
   table_op_type  queued_ops[$];
   table_rsp_type awaited_results[$];

   // Shadow copy of the table. Only slots below shadow_fill are ever read.
   logic [KEY_W-1:0] shadow_keys[CAPACITY];
   logic [TAG_W-1:0] shadow_tags[CAPACITY];
   int unsigned      shadow_fill = 0;

   int unsigned ops_accepted   = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;

   // Both channels run without idling while this window of requests passes.
   wire steady = (ops_accepted >= 250) && (ops_accepted < 330);

   // -------------------------------------------------------------------------
   // Clock and reset. Reset is held at the start and never raised again.
   // All block inputs are given known values at time zero.
   // -------------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_ADD;
      req_chan.deadline = '0;
      req_chan.tag      = '0;
      req_chan.position = '0;
      rsp_chan.ready    = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic void await_result(rsp_status_type status,
                                        logic [RANK_W-1:0] rank,
                                        logic [KEY_W-1:0] key,
                                        logic [TAG_W-1:0] tag,
                                        logic last);
      table_rsp_type rsp;
      rsp.status         = status;
      rsp.rank           = rank;
      rsp.entry_deadline = key;
      rsp.entry_tag      = tag;
      // The count reported is the fill after the operation, in five bits.
      rsp.entry_count    = shadow_fill[COUNT_W-1:0];
      rsp.last           = last;
      awaited_results.push_back(rsp);
   endfunction

   // Stable ascending sort of the occupied slots. Neighbors swap only when
   // the left key is strictly larger, so equal keys keep their order.
   function automatic void sort_shadow_table();
      logic [KEY_W-1:0] held_key;
      logic [TAG_W-1:0] held_tag;
      for (int pass = 0; pass + 1 < int'(shadow_fill); pass++) begin
         for (int j = 0; j + 1 < int'(shadow_fill) - pass; j++) begin
            if (shadow_keys[j] > shadow_keys[j+1]) begin
               held_key         = shadow_keys[j];
               held_tag         = shadow_tags[j];
               shadow_keys[j]   = shadow_keys[j+1];
               shadow_tags[j]   = shadow_tags[j+1];
               shadow_keys[j+1] = held_key;
               shadow_tags[j+1] = held_tag;
            end
         end
      end
   endfunction

   // Applies one accepted request to the shadow table and queues the
   // results it must cause.
   function automatic void apply_to_shadow_table(table_op_type op);
      int unsigned listed;
      case (op.kind)
         KIND_ADD: begin
            if (shadow_fill >= CAPACITY) begin
               await_result(RSP_FULL, '0, '0, '0, 1'b1);
            end else begin
               shadow_keys[shadow_fill] = op.deadline;
               shadow_tags[shadow_fill] = op.tag;
               shadow_fill++;
               await_result(RSP_OK, '0, '0, '0, 1'b1);
            end
         end
         KIND_LIST: begin
            if (shadow_fill == 0) begin
               await_result(RSP_EMPTY, '0, '0, '0, 1'b1);
            end else begin
               sort_shadow_table();
               listed = (shadow_fill < MAX_RESULTS) ? shadow_fill : MAX_RESULTS;
               for (int unsigned i = 0; i < listed; i++) begin
                  await_result(RSP_OK, RANK_W'(i + 1), shadow_keys[i], shadow_tags[i],
                               i + 1 == listed);
               end
            end
         end
         KIND_REMOVE: begin
            if (shadow_fill == 0) begin
               await_result(RSP_EMPTY, '0, '0, '0, 1'b1);
            end else begin
               // The table stays sorted even when the removal is refused.
               sort_shadow_table();
               if (op.position == 0) begin
                  await_result(RSP_CANCEL, '0, '0, '0, 1'b1);
               end else if (op.position > shadow_fill) begin
                  await_result(RSP_INVALID, '0, '0, '0, 1'b1);
               end else begin
                  for (int unsigned i = op.position - 1; i + 1 < shadow_fill; i++) begin
                     shadow_keys[i] = shadow_keys[i+1];
                     shadow_tags[i] = shadow_tags[i+1];
                  end
                  shadow_fill--;
                  await_result(RSP_OK, '0, '0, '0, 1'b1);
               end
            end
         end
         default: begin
            // The unused kind changes nothing and causes no result.
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. A request is predicted at the edge where it is taken.
   // A new request is only put on the channel once the previous one has
   // gone, so valid is never dropped and raised again in one step.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      table_op_type taken;
      table_op_type next_op;
      bit           gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken.kind     = req_chan.kind;
            taken.deadline = req_chan.deadline;
            taken.tag      = req_chan.tag;
            taken.position = req_chan.position;
            apply_to_shadow_table(taken);
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            gap = !steady && ($urandom_range(99) < 25);
            if (queued_ops.size() != 0 && !gap &&
                !(queued_ops[0].hold_until_drained && awaited_results.size() != 0)) begin
               next_op = queued_ops.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.kind     <= next_op.kind;
               req_chan.deadline <= next_op.deadline;
               req_chan.tag      <= next_op.tag;
               req_chan.position <= next_op.position;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor. Every result taken is compared with the oldest
   // prediction. Ready is stalled at random outside the steady window.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      table_rsp_type wanted;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result with none predicted", $realtime);
                  $display("   actual:   status %0d rank %0d key %h tag %h count %0d last %b",
                           rsp_chan.status, rsp_chan.rank, rsp_chan.entry_deadline,
                           rsp_chan.entry_tag, rsp_chan.entry_count, rsp_chan.last);
               end
            end else begin
               wanted = awaited_results.pop_front();
               if (rsp_chan.status !== wanted.status ||
                   rsp_chan.rank !== wanted.rank ||
                   rsp_chan.entry_deadline !== wanted.entry_deadline ||
                   rsp_chan.entry_tag !== wanted.entry_tag ||
                   rsp_chan.entry_count !== wanted.entry_count ||
                   rsp_chan.last !== wanted.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected: status %0d rank %0d key %h tag %h count %0d last %b",
                              wanted.status, wanted.rank, wanted.entry_deadline,
                              wanted.entry_tag, wanted.entry_count, wanted.last);
                     $display("   actual:   status %0d rank %0d key %h tag %h count %0d last %b",
                              rsp_chan.status, rsp_chan.rank, rsp_chan.entry_deadline,
                              rsp_chan.entry_tag, rsp_chan.entry_count, rsp_chan.last);
                  end
               end
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 25);
      end
   end

   // Counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   function automatic void queue_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] deadline,
                                    logic [TAG_W-1:0] tag, logic [POS_W-1:0] position,
                                    bit hold_until_drained);
      table_op_type op;
      op.kind               = kind;
      op.deadline           = deadline;
      op.tag                = tag;
      op.position           = position;
      op.hold_until_drained = hold_until_drained;
      queued_ops.push_back(op);
   endfunction

   initial begin
      int unsigned fill_guess;
      int unsigned mode;
      int unsigned burst_left;
      int unsigned pick;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [POS_W-1:0]  position;

      // Directed part. First the operations on an empty table and the
      // ignored kind code.
      queue_op(KIND_LIST, '0, '0, '0, 1'b0);
      queue_op(KIND_REMOVE, '0, '0, 5'd1, 1'b0);
      queue_op(KIND_UNUSED, 16'($urandom), 16'($urandom), 5'($urandom), 1'b0);

      // Fill the table to capacity: both key extremes, two equal keys with
      // different tags to show the sort is stable, and random keys from a
      // narrow range so that more ties appear.
      queue_op(KIND_ADD, 16'hFFFF, 16'h0000, '0, 1'b0);
      queue_op(KIND_ADD, 16'h0000, 16'hFFFF, '0, 1'b0);
      queue_op(KIND_ADD, 16'h8000, 16'h0001, '0, 1'b0);
      queue_op(KIND_ADD, 16'h8000, 16'h0002, '0, 1'b0);
      for (int i = 4; i < int'(CAPACITY); i++) begin
         queue_op(KIND_ADD, 16'h8000 | 16'($urandom_range(3)), 16'($urandom), '0, 1'b0);
      end

      // Add on a full table, a full listing, removal of the last position,
      // a cancel, and positions past the fill including the largest code.
      queue_op(KIND_ADD, 16'h1234, 16'h5678, '0, 1'b0);
      queue_op(KIND_LIST, '0, '0, '0, 1'b0);
      queue_op(KIND_REMOVE, '0, '0, 5'd16, 1'b0);
      queue_op(KIND_REMOVE, '0, '0, 5'd0, 1'b0);
      queue_op(KIND_REMOVE, '0, '0, 5'd17, 1'b0);
      queue_op(KIND_REMOVE, '0, '0, 5'd31, 1'b0);
      fill_guess = CAPACITY - 1;

      // Random part, in bursts that either grow the table, shrink it, or
      // mix freely, so that both the full and the empty table come up
      // often. Most removals pick a position that exists, to reach the
      // shifting logic, and the rest cancel or go out of range.
      burst_left = 0;
      mode       = 0;
      for (int n = 0; n < int'(RANDOM_OPS); n++) begin
         if (burst_left == 0) begin
            mode       = $urandom_range(2);
            burst_left = $urandom_range(10, 40);
         end
         burst_left--;

         pick = $urandom_range(99);
         case (mode)
            0:       kind = (pick < 65) ? KIND_ADD : (pick < 75) ? KIND_LIST :
                            (pick < 97) ? KIND_REMOVE : KIND_UNUSED;
            1:       kind = (pick < 20) ? KIND_ADD : (pick < 35) ? KIND_LIST :
                            (pick < 97) ? KIND_REMOVE : KIND_UNUSED;
            default: kind = (pick < 40) ? KIND_ADD : (pick < 55) ? KIND_LIST :
                            (pick < 95) ? KIND_REMOVE : KIND_UNUSED;
         endcase

         key  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(7));

         pick = $urandom_range(99);
         if (pick < 70 && fill_guess > 0) begin
            position = 5'($urandom_range(1, fill_guess));
         end else if (pick < 80) begin
            position = '0;
         end else begin
            position = 5'($urandom_range(31));
         end

         if (kind == KIND_ADD && fill_guess < CAPACITY) begin
            fill_guess++;
         end else if (kind == KIND_REMOVE && position != 0 && position <= fill_guess) begin
            fill_guess--;
         end

         // Every so often the sender waits for all results to come back.
         queue_op(kind, key, 16'($urandom), position, (n % 90) == 0);
      end

      // Wait for the run to complete or for the watchdog to fire.
      fork
         begin
            while (queued_ops.size() != 0 || req_chan.valid) @(posedge clock);
            while (awaited_results.size() != 0) @(posedge clock);
            // Give a late or spurious result time to show up.
            repeat (SETTLE_CYCLES) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCHDOG_LIMIT);
         end
      join_any

      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("TEST FAILED");
      end else if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/dstt_pkg.sv
rtl/dstt_req_if.sv
rtl/dstt_rsp_if.sv
rtl/dstt_datapath.sv
rtl/dstt_controller.sv
rtl/deadline_sorted_task_table.sv
tb/testbench.sv
